FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define UVS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define UVS_ASSERT(label, clk, rst_n, cond)
`define UVS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/uvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, constants and rounding helpers for the UV sphere generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int CNT_W          = 9;
	localparam int PH_BITS        = 20;
	localparam int PH_QW          = 21;
	localparam int CORDIC_ITER    = 16;
	localparam int CORDIC_STG     = CORDIC_ITER + 2;
	localparam int IN_W           = 24;
	localparam int OUT_W          = 168;
	localparam int DEF_MAX_SLICES = 256;
	localparam int DEF_MAX_STACKS = 256;

	localparam logic signed [31:0] CORDIC_K30 = 32'sd652032874;
	localparam logic signed [31:0] ONE30      = 32'sh4000_0000;

	localparam logic signed [20:0] ATAN_TAB [CORDIC_ITER] = '{
		21'sd131072, 21'sd77376, 21'sd40884, 21'sd20753,
		21'sd10417,  21'sd5213,  21'sd2607,  21'sd1304,
		21'sd652,    21'sd326,   21'sd163,   21'sd81,
		21'sd41,     21'sd20,    21'sd10,    21'sd5
	};

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_SLICES = 2'd1,
		REG_STACKS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic top;
		logic bot;
	} pole_t;

	// round to nearest, halves away from zero
	function automatic logic signed [63:0] rnd_shift64(input logic signed [63:0] v,
		input int s);
		logic signed [63:0] mag;
		mag = v[63] ? -v : v;
		mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
		return v[63] ? -mag : mag;
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
		input logic signed [63:0] lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = rnd_shift64(v, 30);
		return t[31:0];
	endfunction

	function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
		logic signed [63:0] t;
		t = sat64(rnd_shift64({{32{v[31]}}, v}, 16), 64'sd16384);
		return t[15:0];
	endfunction

	function automatic logic signed [16:0] to_q88(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = sat64(rnd_shift64(v, 30), 64'sd65535);
		return t[16:0];
	endfunction

endpackage

FILE: rtl/uvs_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_delay
// Stall-aware shift line that keeps side data level with the datapath.
// ----------------------------------------------------------------------------
module uvs_delay import uvs_pkg::*; #(
	parameter int W     = 2,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic [DEPTH-1:0] en,
	input  logic [W-1:0]     din,
	output logic [W-1:0]     dout
);

	logic [W-1:0] dl_s [DEPTH];

	for (genvar j = 0; j < DEPTH; j++) begin : g_tap
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[j]) dl_s[j] <= din;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[j]) dl_s[j] <= dl_s[j-1];
			end
		end
	end

	assign dout = dl_s[DEPTH-1];

endmodule

FILE: rtl/uvs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_divider import uvs_pkg::*; #(
	parameter int QW = PH_QW
) (
	input  logic                  clk,
	input  logic [QW-1:0]         en,
	input  logic [QW+CNT_W-1:0]   num,
	input  logic [CNT_W-1:0]      den,
	output logic [QW-1:0]         quo
);

	localparam int NUMW = QW + CNT_W;

	logic [CNT_W-1:0] rem_s [QW];
	logic [QW-1:0]    low_s [QW];
	logic [QW-1:0]    quo_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [CNT_W-1:0] rin;
		logic [QW-1:0]    lin;
		logic [QW-1:0]    qin;
		logic [CNT_W:0]   t;
		logic             ge;
		if (j == 0) begin : g_first
			// quotient fits QW bits, so the top part is already below den
			assign rin = num[NUMW-1:QW];
			assign lin = num[QW-1:0];
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[j-1];
			assign lin = low_s[j-1];
			assign qin = quo_s[j-1];
		end
		assign t  = {rin, lin[QW-1-j]};
		assign ge = (t >= {1'b0, den});
		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= ge ? CNT_W'(t - {1'b0, den}) : t[CNT_W-1:0];
				low_s[j] <= lin;
				quo_s[j] <= {qin[QW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

FILE: rtl/uvs_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation CORDIC: cosine and sine of a phase as Q1.30.
// ----------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; (
	input  logic                    clk,
	input  logic [CORDIC_STG-1:0]   en,
	input  logic [PH_BITS-1:0]      phase,
	output logic signed [31:0]      cos_o,
	output logic signed [31:0]      sin_o
);

	localparam logic signed [20:0] PH_HALF    = 21'sd524288;
	localparam logic signed [20:0] PH_QUARTER = 21'sd262144;

	// fold into a quarter turn either side of zero
	logic signed [20:0] d0, d1;
	logic               ng0;
	always_comb begin
		d0 = (phase > PH_BITS'(PH_HALF)) ? 21'($signed({1'b0, phase}) - 2 * PH_HALF)
			: $signed({1'b0, phase});
		ng0 = 1'b0;
		d1  = d0;
		if (d0 > PH_QUARTER) begin
			d1  = d0 - PH_HALF;
			ng0 = 1'b1;
		end else if (d0 < -PH_QUARTER) begin
			d1  = d0 + PH_HALF;
			ng0 = 1'b1;
		end
	end

	logic               ex_f_s, ng_f_s;
	logic [1:0]         qd_f_s;
	logic signed [20:0] z_f_s;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ex_f_s <= (phase[PH_BITS-3:0] == '0);
			qd_f_s <= phase[PH_BITS-1:PH_BITS-2];
			ng_f_s <= ng0;
			z_f_s  <= d1;
		end
	end

	logic signed [31:0] x_s  [CORDIC_ITER];
	logic signed [31:0] y_s  [CORDIC_ITER];
	logic signed [20:0] z_s  [CORDIC_ITER];
	logic               ex_s [CORDIC_ITER];
	logic               ng_s [CORDIC_ITER];
	logic [1:0]         qd_s [CORDIC_ITER];

	for (genvar i = 0; i < CORDIC_ITER; i++) begin : g_iter
		logic signed [31:0] xi, yi;
		logic signed [20:0] zi;
		logic               exi, ngi;
		logic [1:0]         qdi;
		if (i == 0) begin : g_first
			assign xi  = CORDIC_K30;
			assign yi  = '0;
			assign zi  = z_f_s;
			assign exi = ex_f_s;
			assign ngi = ng_f_s;
			assign qdi = qd_f_s;
		end else begin : g_next
			assign xi  = x_s[i-1];
			assign yi  = y_s[i-1];
			assign zi  = z_s[i-1];
			assign exi = ex_s[i-1];
			assign ngi = ng_s[i-1];
			assign qdi = qd_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				if (!zi[20]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN_TAB[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN_TAB[i];
				end
				ex_s[i] <= exi;
				ng_s[i] <= ngi;
				qd_s[i] <= qdi;
			end
		end
	end

	localparam int L = CORDIC_ITER - 1;

	always_ff @(posedge clk) begin
		if (en[CORDIC_STG-1]) begin
			if (ex_s[L]) begin
				// exact quarter turns
				case (qd_s[L])
					2'd0: begin cos_o <= ONE30;  sin_o <= '0;     end
					2'd1: begin cos_o <= '0;     sin_o <= ONE30;  end
					2'd2: begin cos_o <= -ONE30; sin_o <= '0;     end
					default: begin cos_o <= '0;  sin_o <= -ONE30; end
				endcase
			end else begin
				cos_o <= ng_s[L] ? -x_s[L] : x_s[L];
				sin_o <= ng_s[L] ? -y_s[L] : y_s[L];
			end
		end
	end

endmodule

FILE: rtl/uv_sphere_vertex_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// Position, uv, normal and tangent of one UV sphere grid point per beat.
// ----------------------------------------------------------------------------
//  channel   dir  payload (lowest bits first)
//  s_axis    in   stack_index[8:0], slice_index[17:9]
//  m_axis    out  pos_x/y/z, tex_u/v, normal_x/y/z, tangent_x/y/z (168 bits)
//  cfg       in   cfg_we, cfg_index (0 radius, 1 slices, 2 stacks), cfg_wdata
//
//  One beat in per cycle unless the output stalls. Stages: one clamp stage, 21
//  divider stages (one quotient bit each), 18 CORDIC stages, then multiply,
//  round, scale and output stages.
//  Every stage has its own valid bit and advances when the next stage is
//  empty or advancing, so a stalled output only holds the stages behind it.
//  Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uv_sphere_vertex_generator_unit import uvs_pkg::*; #(
	parameter int MAX_SLICES = DEF_MAX_SLICES,
	parameter int MAX_STACKS = DEF_MAX_STACKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // stack_index, slice_index
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
	                                     // normal_x, normal_y, normal_z,
	                                     // tangent_x, tangent_y, tangent_z
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);

	localparam int ST_DIV_END  = 1 + PH_QW;
	localparam int ST_CORD_END = ST_DIV_END + CORDIC_STG;
	localparam int ST_A        = ST_CORD_END + 1;
	localparam int ST_B        = ST_A + 1;
	localparam int ST_C        = ST_B + 1;
	localparam int N_STG       = ST_C + 1;
	localparam int NUMW        = PH_QW + CNT_W;

	// ---------------- configuration registers ----------------
	logic [15:0]      radius_q;
	logic [CNT_W-1:0] slices_q, stacks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			slices_q <= 9'd16;
			stacks_q <= 9'd16;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_RADIUS: radius_q <= cfg_wdata;
				REG_SLICES: slices_q <= cfg_wdata[CNT_W-1:0];
				REG_STACKS: stacks_q <= cfg_wdata[CNT_W-1:0];
				default: ;  // drop writes to unknown indices
			endcase
		end
	end

	// clamp counts; user must change them only while the pipe is empty, unenforced
	logic [CNT_W-1:0] slices_c, stacks_c;
	always_comb begin
		slices_c = (slices_q < 9'd3) ? 9'd3 : slices_q;
		if (int'(slices_c) > MAX_SLICES) slices_c = CNT_W'(MAX_SLICES);
		stacks_c = (stacks_q < 9'd2) ? 9'd2 : stacks_q;
		if (int'(stacks_c) > MAX_STACKS) stacks_c = CNT_W'(MAX_STACKS);
	end

	// ---------------- pipeline control ----------------
	logic [N_STG:1] vld_q;
	logic [N_STG:1] en;

	// a stage may load when it is empty or its content moves on
	always_comb begin
		en[N_STG] = !vld_q[N_STG] || m_tready;
		for (int k = N_STG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= N_STG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[N_STG];

	// ---------------- stage 1: clamp indices, flag poles ----------------
	logic [CNT_W-1:0] st_in, sl_in;
	logic [CNT_W-1:0] st_s1, sl_s1;
	pole_t            pole_s1;

	assign st_in = s_tdata[CNT_W-1:0];
	assign sl_in = s_tdata[2*CNT_W-1:CNT_W];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			st_s1       <= (st_in > stacks_c) ? stacks_c : st_in;
			sl_s1       <= (sl_in > slices_c) ? slices_c : sl_in;
			pole_s1.top <= (st_in == '0);
			pole_s1.bot <= (st_in >= stacks_c);
		end
	end

	// ---------------- dividers: phases and texture coordinates ----------------
	logic [NUMW-1:0]  tnum, pnum, unum, vnum;
	logic [PH_QW-1:0] tph, pph, uq, vq;

	// numerators with half the divisor added, so the quotient rounds
	assign tnum = NUMW'({sl_s1, 20'd0}) + NUMW'(slices_c[CNT_W-1:1]);
	assign pnum = NUMW'({st_s1, 19'd0}) + NUMW'(stacks_c[CNT_W-1:1]);
	assign unum = NUMW'({sl_s1, 16'd0}) + NUMW'(slices_c[CNT_W-1:1]);
	assign vnum = NUMW'({st_s1, 16'd0}) + NUMW'(stacks_c[CNT_W-1:1]);

	uvs_divider #(.QW(PH_QW)) u_div_t (
		.clk(clk), .en(en[ST_DIV_END:2]), .num(tnum), .den(slices_c), .quo(tph));
	uvs_divider #(.QW(PH_QW)) u_div_p (
		.clk(clk), .en(en[ST_DIV_END:2]), .num(pnum), .den(stacks_c), .quo(pph));
	uvs_divider #(.QW(PH_QW)) u_div_u (
		.clk(clk), .en(en[ST_DIV_END:2]), .num(unum), .den(slices_c), .quo(uq));
	uvs_divider #(.QW(PH_QW)) u_div_v (
		.clk(clk), .en(en[ST_DIV_END:2]), .num(vnum), .den(stacks_c), .quo(vq));

	// ---------------- side data held level with the datapath ----------------
	pole_t       pole_c;
	logic [33:0] uv_c;

	uvs_delay #(.W(2), .DEPTH(ST_C - 1)) u_dly_pole (
		.clk(clk), .en(en[ST_C:2]), .din(pole_s1), .dout(pole_c));
	uvs_delay #(.W(34), .DEPTH(ST_C - ST_DIV_END)) u_dly_uv (
		.clk(clk), .en(en[ST_C:ST_DIV_END+1]), .din({vq[16:0], uq[16:0]}),
		.dout(uv_c));

	// ---------------- CORDIC for both angles ----------------
	logic signed [31:0] cp, sp, ct, stt;

	uvs_cordic u_cord_p (
		.clk(clk), .en(en[ST_CORD_END:ST_DIV_END+1]), .phase(pph[PH_BITS-1:0]),
		.cos_o(cp), .sin_o(sp));
	uvs_cordic u_cord_t (
		.clk(clk), .en(en[ST_CORD_END:ST_DIV_END+1]), .phase(tph[PH_BITS-1:0]),
		.cos_o(ct), .sin_o(stt));

	// ---------------- stage A: sin phi times cos / sin theta ----------------
	logic signed [63:0] axp_s41, azp_s41;
	logic signed [31:0] cp_s41, ct_s41, stt_s41;

	always_ff @(posedge clk) begin
		if (en[ST_A]) begin
			axp_s41 <= sp * ct;
			azp_s41 <= sp * stt;
			cp_s41  <= cp;
			ct_s41  <= ct;
			stt_s41 <= stt;
		end
	end

	// ---------------- stage B: round products back to Q1.30 ----------------
	logic signed [31:0] ax_s42, az_s42, cp_s42, ct_s42, stt_s42;

	always_ff @(posedge clk) begin
		if (en[ST_B]) begin
			ax_s42  <= rnd30(axp_s41);
			az_s42  <= rnd30(azp_s41);
			cp_s42  <= cp_s41;
			ct_s42  <= ct_s41;
			stt_s42 <= stt_s41;
		end
	end

	// ---------------- stage C: scale by radius, form unit vectors ----------------
	logic signed [16:0] rad_sg;
	logic signed [63:0] pxp_s43, pyp_s43, pzp_s43;
	logic signed [15:0] nx_s43, ny_s43, nz_s43, tx_s43, tz_s43;

	assign rad_sg = $signed({1'b0, radius_q});

	always_ff @(posedge clk) begin
		if (en[ST_C]) begin
			pxp_s43 <= rad_sg * ax_s42;
			pyp_s43 <= rad_sg * cp_s42;
			pzp_s43 <= rad_sg * az_s42;
			nx_s43  <= to_q14(ax_s42);
			ny_s43  <= to_q14(cp_s42);
			nz_s43  <= to_q14(az_s42);
			tx_s43  <= to_q14(-stt_s42);
			tz_s43  <= to_q14(ct_s42);
		end
	end

	// ---------------- stage D: round positions, pole override ----------------
	logic [OUT_W-1:0] out_s44;

	always_ff @(posedge clk) begin
		if (en[N_STG]) begin
			if (pole_c.top || pole_c.bot) begin
				// poles: fixed uv and tangent, slice ignored
				out_s44 <= {
					2'b00,
					16'sd0, 1'b0, 16'sd16384,
					16'sd0, pole_c.top ? 16'sd16384 : -16'sd16384, 16'sd0,
					pole_c.top ? 17'd0 : 17'd65536, 17'd32768,
					17'sd0, pole_c.top ? rad_sg : -rad_sg, 17'sd0
				};
			end else begin
				out_s44 <= {
					2'b00,
					tz_s43, 1'b0, tx_s43,
					nz_s43, ny_s43, nx_s43,
					uv_c[33:17], uv_c[16:0],
					to_q88(pzp_s43), to_q88(pyp_s43), to_q88(pxp_s43)
				};
			end
		end
	end

	assign m_tdata = out_s44;

	// ---------------- checks ----------------
	`UVS_ASSERT(a_ready_when_out_empty, clk, arst_n, m_tvalid || s_tready)
	`UVS_ASSERT(a_ready_when_out_taken, clk, arst_n, !m_tready || s_tready)
	`UVS_ASSERT_NEXT(a_accept_lands, clk, arst_n, s_tvalid && s_tready, vld_q[1])

endmodule
